FILE: rtl/lome_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lome_pkg: shared types and constants of the order matching engine
// Item structs, operation codes and the sequencer states.
// ----------------------------------------------------------------------------
package lome_pkg;

   localparam logic [19:0] START_MIN_PRICE = 20'd1000000;

   typedef enum logic [1:0] {
      OP_BUY    = 2'd0,
      OP_SELL   = 2'd1,
      OP_CANCEL = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] order_number;
      logic [2:0]  stock_index;
      logic [15:0] order_quantity;
      logic [19:0] limit_price;
   } req_type;

   typedef struct packed {
      logic [15:0] unfilled_quantity;
      logic [19:0] best_profit;
      logic        book_full;
   } rsp_type;

   // book entry: order number, quantity, price
   typedef struct packed {
      logic [15:0] num;
      logic [15:0] qty;
      logic [19:0] price;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MARK_RD,
      ST_TOP_RD,
      ST_TOP_WAIT,
      ST_TOP_CHK,
      ST_MARK_WAIT,
      ST_MATCH,
      ST_POP_START,
      ST_POP_LAST_WAIT,
      ST_POP_KIDS,
      ST_POP_L_WAIT,
      ST_POP_R_WAIT,
      ST_POP_CMP,
      ST_PUSH_START,
      ST_PUSH_UP,
      ST_PUSH_PAR_WAIT,
      ST_PUSH_CMP,
      ST_DONE
   } state_type;

   // side 0: asks (low price first), side 1: bids (high price first)
   function automatic logic ahead(input logic side, input entry_type a,
                                  input entry_type b);
      logic r;
      if (a.price != b.price) begin
         r = side ? (a.price > b.price) : (a.price < b.price);
      end else begin
         r = a.num < b.num;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/lome_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lome_ram: generic single-port synchronous RAM
// One write or one read a cycle, read data registered.
// ----------------------------------------------------------------------------
module lome_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/limit_order_matching_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_matching_engine: per-stock bid/ask heaps with matching
// Sequencer over a book RAM (binary heaps) and a cancel-mark RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one order item (buy, sell, cancel); rsp_ channel
//   returns one result item per order, in order. Both use valid/ready.
//   One item is worked at a time. A buy or sell reads and checks each top
//   of the opposite book in turn, trades against it, and removes it from
//   the top when it is filled or was cancelled, sifting down up to
//   log2(BOOK_DEPTH) heap levels; any remainder is then stored and climbs
//   its own heap. The single port of the book RAM serialises these reads
//   and writes.
//   After reset the cancel-mark RAM is cleared one entry a cycle;
//   req_ready stays low meanwhile.
//   A result waits in the output register while rsp_ready is low; the
//   next item is taken the cycle after that result has gone.
// ----------------------------------------------------------------------------
module limit_order_matching_engine
   import lome_pkg::*;
#(
   parameter int NUM_STOCKS = 5,
   parameter int BOOK_DEPTH = 1024,
   parameter int MAX_ORDERS = 65536
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   localparam int NB   = 2 * NUM_STOCKS;
   localparam int BW   = $clog2(NB);
   localparam int DW   = $clog2(BOOK_DEPTH);
   localparam int CW   = $clog2(BOOK_DEPTH + 1);
   localparam int AW   = BW + DW;
   localparam int MW   = $clog2(MAX_ORDERS);
   localparam int SW   = $clog2(NUM_STOCKS + 1);

   // book RAM: one row of BOOK_DEPTH entries per book
   logic            bk_we;
   logic [AW-1:0]   bk_addr;
   entry_type       bk_wd, bk_rd;
   lome_ram #(.WIDTH($bits(entry_type)), .DEPTH(NB * (2 ** DW))) u_book (
      .clock(clock), .wr_en(bk_we), .addr(bk_addr), .wr_data(bk_wd),
      .rd_data(bk_rd));

   logic            mk_we;
   logic [MW-1:0]   mk_addr;
   logic            mk_wd, mk_rd;
   lome_ram #(.WIDTH(1), .DEPTH(2 ** MW)) u_mark (
      .clock(clock), .wr_en(mk_we), .addr(mk_addr), .wr_data(mk_wd),
      .rd_data(mk_rd));

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff [NB];
   logic [CW-1:0]   cnt_wr;
   logic            cnt_we;
   logic [19:0]     minp_ff [NUM_STOCKS];
   logic [19:0]     prof_ff [NUM_STOCKS];
   logic            trade_we;
   logic [MW:0]     clr_ff, clr_in;

   req_type         req_ff, req_in;
   logic [15:0]     qty_ff, qty_in;
   logic            full_ff, full_in;
   entry_type       top_ff, top_in;
   entry_type       last_ff, last_in;
   entry_type       lch_ff, lch_in;
   logic            rsel_ff, rsel_in;
   logic [DW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   n_ff, n_in;
   logic            rv_ff, rv_in;
   rsp_type         rd_ff, rd_in;

   logic [SW-1:0]   stk;
   logic            stk_ok;
   logic [BW-1:0]   opp, own, book;
   logic            side;
   logic [CW-1:0]   cnt_opp, cnt_own;
   logic            num_ok;
   logic [DW:0]     lidx;
   logic [DW-1:0]   pidx;
   entry_type       newe;

   assign stk     = SW'(req_ff.stock_index);
   assign stk_ok  = 32'(req_ff.stock_index) < NUM_STOCKS;
   assign side    = req_ff.operation[0];
   assign opp     = BW'(32'(stk) * 2 + 32'(side));
   assign own     = BW'(32'(stk) * 2 + 32'(!side));
   assign cnt_opp = cnt_ff[opp];
   assign cnt_own = cnt_ff[own];
   assign num_ok  = 32'(req_ff.order_number) < MAX_ORDERS;
   assign lidx    = {idx_ff, 1'b1};
   assign pidx    = DW'((32'(idx_ff) - 1) >> 1);
   assign newe    = '{num: req_ff.order_number, qty: qty_ff,
                      price: req_ff.limit_price};
   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         for (int b = 0; b < NB; b++) cnt_ff[b] <= '0;
         for (int s = 0; s < NUM_STOCKS; s++) begin
            minp_ff[s] <= START_MIN_PRICE;
            prof_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         if (cnt_we) cnt_ff[book] <= cnt_wr;
         if (trade_we) begin
            if (minp_ff[stk] > top_ff.price) begin
               minp_ff[stk] <= top_ff.price;
            end else if (top_ff.price - minp_ff[stk] > prof_ff[stk]) begin
               prof_ff[stk] <= top_ff.price - minp_ff[stk];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      qty_ff  <= qty_in;
      full_ff <= full_in;
      top_ff  <= top_in;
      last_ff <= last_in;
      lch_ff  <= lch_in;
      rsel_ff <= rsel_in;
      idx_ff  <= idx_in;
      n_ff    <= n_in;
      rd_ff   <= rd_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      rv_in    = rv_ff;
      req_in   = req_ff;
      qty_in   = qty_ff;
      full_in  = full_ff;
      top_in   = top_ff;
      last_in  = last_ff;
      lch_in   = lch_ff;
      rsel_in  = rsel_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      rd_in    = rd_ff;
      bk_we    = 1'b0;
      bk_addr  = {opp, idx_ff};
      bk_wd    = last_ff;
      mk_we    = 1'b0;
      mk_addr  = MW'(req_ff.order_number);
      mk_wd    = 1'b1;
      cnt_we   = 1'b0;
      cnt_wr   = n_ff;
      book     = opp;
      trade_we = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mk_we   = 1'b1;
            mk_wd   = 1'b0;
            mk_addr = clr_ff[MW-1:0];
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == (2 ** MW) - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in   = req_data;
               qty_in   = req_data.order_quantity;
               full_in  = 1'b0;
               state_in = ST_MARK_RD;
            end
         end
         ST_MARK_RD: begin
            if (req_ff.operation == OP_CANCEL) begin
               mk_we = num_ok;
               qty_in = '0;
               state_in = ST_DONE;
            end else if (req_ff.operation == OP_NONE) begin
               qty_in = '0;
               state_in = ST_DONE;
            end else if (!stk_ok) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_TOP_RD;
            end
         end
         ST_TOP_RD: begin
            if (qty_ff == '0) begin
               state_in = ST_DONE;
            end else if (cnt_opp == '0) begin
               state_in = ST_PUSH_START;
            end else begin
               bk_addr  = {opp, DW'(0)};
               state_in = ST_TOP_WAIT;
            end
         end
         ST_TOP_WAIT: begin
            top_in   = bk_rd;
            state_in = ST_TOP_CHK;
         end
         ST_TOP_CHK: begin
            mk_addr  = MW'(top_ff.num);
            state_in = ST_MARK_WAIT;
         end
         ST_MARK_WAIT: begin
            if (mk_rd && 32'(top_ff.num) < MAX_ORDERS) begin
               state_in = ST_POP_START;
            end else if (side ? (top_ff.price < req_ff.limit_price)
                              : (top_ff.price > req_ff.limit_price)) begin
               state_in = ST_PUSH_START;
            end else begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            trade_we = 1'b1;
            if (qty_ff < top_ff.qty) begin
               bk_we    = 1'b1;
               bk_addr  = {opp, DW'(0)};
               bk_wd    = top_ff;
               bk_wd.qty = top_ff.qty - qty_ff;
               qty_in   = '0;
               state_in = ST_DONE;
            end else begin
               qty_in   = qty_ff - top_ff.qty;
               state_in = ST_POP_START;
            end
         end
         ST_POP_START: begin
            n_in     = cnt_opp - 1'b1;
            cnt_we   = 1'b1;
            cnt_wr   = cnt_opp - 1'b1;
            idx_in   = '0;
            bk_addr  = {opp, DW'(cnt_opp - 1'b1)};
            if (cnt_opp == CW'(1)) state_in = ST_TOP_RD;
            else state_in = ST_POP_LAST_WAIT;
         end
         ST_POP_LAST_WAIT: begin
            last_in  = bk_rd;
            state_in = ST_POP_KIDS;
         end
         ST_POP_KIDS: begin
            if (32'(lidx) >= 32'(n_ff)) begin
               bk_we    = 1'b1;
               state_in = ST_TOP_RD;
            end else begin
               bk_addr  = {opp, DW'(lidx)};
               state_in = ST_POP_L_WAIT;
            end
         end
         ST_POP_L_WAIT: begin
            lch_in  = bk_rd;
            rsel_in = 1'b0;
            if (32'(lidx) + 1 < 32'(n_ff)) begin
               bk_addr  = {opp, DW'(lidx + 1'b1)};
               state_in = ST_POP_R_WAIT;
            end else begin
               state_in = ST_POP_CMP;
            end
         end
         ST_POP_R_WAIT: begin
            // right child taken only when strictly ahead of the left
            if (ahead(side, bk_rd, lch_ff)) begin
               lch_in  = bk_rd;
               rsel_in = 1'b1;
            end
            state_in = ST_POP_CMP;
         end
         ST_POP_CMP: begin
            bk_we = 1'b1;
            if (ahead(side, lch_ff, last_ff)) begin
               bk_wd    = lch_ff;
               idx_in   = DW'(lidx + {{DW{1'b0}}, rsel_ff});
               state_in = ST_POP_KIDS;
            end else begin
               state_in = ST_TOP_RD;
            end
         end
         ST_PUSH_START: begin
            book = own;
            if (32'(cnt_own) >= BOOK_DEPTH) begin
               full_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               cnt_we   = 1'b1;
               cnt_wr   = cnt_own + 1'b1;
               idx_in   = DW'(cnt_own);
               state_in = ST_PUSH_UP;
            end
         end
         ST_PUSH_UP: begin
            if (idx_ff == '0) begin
               bk_we    = 1'b1;
               bk_addr  = {own, idx_ff};
               bk_wd    = newe;
               state_in = ST_DONE;
            end else begin
               bk_addr  = {own, pidx};
               state_in = ST_PUSH_PAR_WAIT;
            end
         end
         ST_PUSH_PAR_WAIT: begin
            // lch holds the parent during the climb
            lch_in   = bk_rd;
            state_in = ST_PUSH_CMP;
         end
         ST_PUSH_CMP: begin
            bk_we   = 1'b1;
            bk_addr = {own, idx_ff};
            if (ahead(!side, newe, lch_ff)) begin
               bk_wd    = lch_ff;
               idx_in   = pidx;
               state_in = ST_PUSH_UP;
            end else begin
               bk_wd    = newe;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rd_in.unfilled_quantity = (req_ff.operation[1] == 1'b0) ? qty_ff : '0;
            rd_in.best_profit       = stk_ok ? prof_ff[stk] : '0;
            rd_in.book_full         = full_ff;
            rv_in                   = 1'b1;
            state_in                = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire
